// ===== rtl/npts_pkg.sv =====
// Package for the node phase transition sweep core.
// Holds the phase codes, register indexes, shared structs and the saturating timer add.
// It has no dependencies and is compiled first.
`default_nettype none

package npts_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_AMO_SOLIDUS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AMO_LIQUIDUS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CRY_LIQUIDUS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NUC_ENERGY   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SUPPORT_DLY  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_NUCLEUS_DLY  = 3'd5;

  localparam logic [3:0] PH_CRYSTAL     = 4'd1;
  localparam logic [3:0] PH_LARGE_POLY  = 4'd2;
  localparam logic [3:0] PH_FINE_POLY   = 4'd3;
  localparam logic [3:0] PH_AMORPHOUS   = 4'd4;
  localparam logic [3:0] PH_MUSHY_AMO   = 4'd5;
  localparam logic [3:0] PH_MUSHY_CRY   = 4'd6;
  localparam logic [3:0] PH_MUSHY_FINE  = 4'd7;
  localparam logic [3:0] PH_LIQUID      = 4'd8;
  localparam logic [3:0] PH_SUPERCOOLED = 4'd9;

  localparam logic signed [31:0] CRYSTAL_SOLIDUS = 32'sd0;
  localparam logic [31:0]        TIMER_MAX       = 32'hFFFF_FFFF;

  typedef struct packed {
    logic signed [31:0] amorphous_solidus;
    logic signed [31:0] amorphous_liquidus;
    logic signed [31:0] crystal_liquidus;
    logic signed [31:0] nucleation_energy_limit;
    logic [31:0]        support_delay;
    logic [31:0]        nucleus_delay;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] node_energy;
    logic [3:0]         node_phase;
    logic [3:0]         right_phase;
    logic               surface_node;
    logic [31:0]        support_timer;
    logic [31:0]        nucleus_timer;
    logic [23:0]        time_step;
    logic               front_fast;
  } node_in_t;

  typedef struct packed {
    logic [3:0]  new_phase;
    logic [31:0] new_support_timer;
    logic [31:0] new_nucleus_timer;
  } node_out_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [23:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {9'b0, b};
    return s[32] ? TIMER_MAX : s[31:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/npts_if.sv =====
// Valid/ready channel interfaces for node items and result items.
// Depends on nothing; compiled after npts_pkg.
`default_nettype none

interface npts_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] node_energy;
  logic [3:0]         node_phase;
  logic [3:0]         right_phase;
  logic               surface_node;
  logic [31:0]        support_timer;
  logic [31:0]        nucleus_timer;
  logic [23:0]        time_step;
  logic               front_fast;

  modport source (
    output valid, node_energy, node_phase, right_phase, surface_node,
    output support_timer, nucleus_timer, time_step, front_fast,
    input  ready
  );
  modport sink (
    input  valid, node_energy, node_phase, right_phase, surface_node,
    input  support_timer, nucleus_timer, time_step, front_fast,
    output ready
  );
endinterface

interface npts_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  new_phase;
  logic [31:0] new_support_timer;
  logic [31:0] new_nucleus_timer;

  modport source (
    output valid, new_phase, new_support_timer, new_nucleus_timer,
    input  ready
  );
  modport sink (
    input  valid, new_phase, new_support_timer, new_nucleus_timer,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/npts_rule.sv =====
// Phase transition rules for one node, purely combinational.
// Depends on npts_pkg for the phase codes, structs and sat_add.
`default_nettype none

module npts_rule (
  input  npts_pkg::node_in_t  node_i,
  input  npts_pkg::cfg_t      cfg_i,
  input  logic [3:0]          left_phase_i,
  output npts_pkg::node_out_t node_o
);
  import npts_pkg::*;

  logic signed [31:0] e;
  logic [3:0]         ph;
  logic [3:0]         rp;
  logic [3:0]         lp;
  logic [3:0]         np;
  logic [31:0]        t1;
  logic [31:0]        t2;
  logic               solid_near;

  assign e  = node_i.node_energy;
  assign ph = node_i.node_phase;
  assign rp = node_i.right_phase;
  assign lp = node_i.surface_node ? rp : left_phase_i;
  assign solid_near = (rp < PH_AMORPHOUS) || (lp < PH_AMORPHOUS);

  always_comb begin
    np = ph;
    t1 = node_i.support_timer;
    t2 = node_i.nucleus_timer;
    unique case (ph)
      PH_CRYSTAL, PH_LARGE_POLY: begin
        if (e >= CRYSTAL_SOLIDUS) np = PH_MUSHY_CRY;
      end
      PH_FINE_POLY: begin
        if (e >= CRYSTAL_SOLIDUS) np = PH_MUSHY_FINE;
      end
      PH_AMORPHOUS: begin
        if (e >= cfg_i.amorphous_solidus) np = PH_MUSHY_AMO;
      end
      PH_MUSHY_AMO: begin
        if (e < cfg_i.amorphous_solidus) np = PH_AMORPHOUS;
        if (e >= cfg_i.amorphous_liquidus) np = PH_SUPERCOOLED;
      end
      PH_MUSHY_CRY: begin
        if (e > cfg_i.crystal_liquidus) begin
          np = PH_LIQUID;
        end else if (e < CRYSTAL_SOLIDUS) begin
          np = ((rp == PH_CRYSTAL) || (lp == PH_CRYSTAL)) ? PH_CRYSTAL : PH_LARGE_POLY;
        end else if (node_i.front_fast) begin
          if (e > cfg_i.amorphous_solidus) np = PH_MUSHY_AMO;
          if (e > cfg_i.amorphous_liquidus) np = PH_SUPERCOOLED;
        end
      end
      PH_MUSHY_FINE: begin
        if (e < CRYSTAL_SOLIDUS) np = PH_FINE_POLY;
        if (e > cfg_i.crystal_liquidus) np = PH_LIQUID;
      end
      PH_LIQUID: begin
        if (e < cfg_i.crystal_liquidus) np = solid_near ? PH_MUSHY_CRY : PH_SUPERCOOLED;
      end
      PH_SUPERCOOLED: begin
        if (e >= cfg_i.crystal_liquidus) begin
          np = PH_LIQUID;
        end else if (e < cfg_i.amorphous_liquidus) begin
          np = PH_MUSHY_AMO;
        end else begin
          t2 = (e < cfg_i.nucleation_energy_limit) ?
               sat_add(node_i.nucleus_timer, node_i.time_step) : '0;
          if (rp == PH_CRYSTAL) begin
            np = PH_MUSHY_CRY;
          end else begin
            t1 = solid_near ? sat_add(node_i.support_timer, node_i.time_step) : '0;
            if (t1 > cfg_i.support_delay) np = PH_MUSHY_CRY;
            if ((np == PH_MUSHY_CRY) && !node_i.surface_node &&
                (left_phase_i == PH_FINE_POLY)) np = PH_MUSHY_FINE;
            if (t2 > cfg_i.nucleus_delay) np = PH_MUSHY_FINE;
          end
        end
      end
      default: begin
        np = ph;
      end
    endcase
  end

  assign node_o.new_phase         = np;
  assign node_o.new_support_timer = t1;
  assign node_o.new_nucleus_timer = t2;

endmodule

`default_nettype wire

// ===== rtl/node_phase_transition_sweep_core.sv =====
// Node phase transition sweep core: top level.
// Each node is loaded into the input register and its result into the output register, and
// result valid rises once the result is loaded there; one node per cycle sustained, input held only when both
// registers are full and the result is not taken. The input register feeds the rule logic.
// Synchronous active-low reset clears both valid flags, the left phase (to crystal)
// and all configuration registers (to zero). Depends on npts_pkg, npts_if and npts_rule.
`default_nettype none

module node_phase_transition_sweep_core (
  input  logic                              clk,
  input  logic                              rst_n,
  npts_in_if.sink                           in_ch,
  npts_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [npts_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [npts_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import npts_pkg::*;

  cfg_t      cfg_r;
  cfg_t      cfg_nxt;
  node_in_t  in_d;
  node_in_t  s1_r;
  logic      s1_valid_r;
  logic      s1_valid_nxt;
  logic      s1_adv;
  logic      out_free;
  logic      in_xfer;
  logic [3:0] left_phase_r;
  node_out_t rule_out;
  node_out_t out_r;
  logic      out_valid_r;
  logic      out_valid_nxt;

  assign in_d.node_energy   = in_ch.node_energy;
  assign in_d.node_phase    = in_ch.node_phase;
  assign in_d.right_phase   = in_ch.right_phase;
  assign in_d.surface_node  = in_ch.surface_node;
  assign in_d.support_timer = in_ch.support_timer;
  assign in_d.nucleus_timer = in_ch.nucleus_timer;
  assign in_d.time_step     = in_ch.time_step;
  assign in_d.front_fast    = in_ch.front_fast;

  assign out_free     = !out_valid_r || out_ch.ready;
  assign s1_adv       = s1_valid_r && out_free;
  assign in_ch.ready  = !s1_valid_r || out_free;
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign s1_valid_nxt = in_xfer || (s1_valid_r && !out_free);
  assign out_valid_nxt = s1_adv || (out_valid_r && !out_ch.ready);

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        CFG_AMO_SOLIDUS:  cfg_nxt.amorphous_solidus       = cfg_wdata;
        CFG_AMO_LIQUIDUS: cfg_nxt.amorphous_liquidus      = cfg_wdata;
        CFG_CRY_LIQUIDUS: cfg_nxt.crystal_liquidus        = cfg_wdata;
        CFG_NUC_ENERGY:   cfg_nxt.nucleation_energy_limit = cfg_wdata;
        CFG_SUPPORT_DLY:  cfg_nxt.support_delay           = cfg_wdata;
        CFG_NUCLEUS_DLY:  cfg_nxt.nucleus_delay           = cfg_wdata;
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  npts_rule u_rule (
    .node_i       (s1_r),
    .cfg_i        (cfg_r),
    .left_phase_i (left_phase_r),
    .node_o       (rule_out)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r        <= '0;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      left_phase_r <= PH_CRYSTAL;
    end else begin
      cfg_r       <= cfg_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_adv) left_phase_r <= rule_out.new_phase;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) s1_r <= in_d;
    if (s1_adv) out_r <= rule_out;
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.new_phase         = out_r.new_phase;
  assign out_ch.new_support_timer = out_r.new_support_timer;
  assign out_ch.new_nucleus_timer = out_r.new_nucleus_timer;

  a_left_tracks_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> (left_phase_r == $past(rule_out.new_phase)))
    else $error("left phase does not follow the last result");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_ch.ready)
    else $error("input stage empty but not ready");

  a_out_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r))
    else $error("result appeared without an item in the input stage");

  a_unknown_phase_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && ((s1_r.node_phase == 4'd0) || (s1_r.node_phase > PH_SUPERCOOLED)))
    |-> (rule_out.new_phase == s1_r.node_phase))
    else $error("undefined phase code was altered");

endmodule

`default_nettype wire
